/* hdl/mfn_pkg.sv */
// Package for the mixed fraction normaliser.
// Holds the transaction payload types, status codes and sequencer states.
// No dependencies.
package mfn_pkg;

  typedef struct packed {
    logic [31:0] num_in;
    logic [31:0] den_in;
    logic [31:0] whole_in;
  } in_t;

  typedef struct packed {
    logic [31:0] whole_out;
    logic [31:0] num_out;
    logic [31:0] den_out;
    logic [1:0]  status;
  } out_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN  = 2'd1;
  localparam logic [1:0] ST_SATURATED = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXTRACT,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_DONE
  } state_t;

endpackage

/* hdl/mfn_divider.sv */
// Radix-2 restoring divider producing one quotient bit per cycle.
// Used for the whole-part extraction, every Euclid step and the final reductions.
// No package dependencies.
module mfn_divider #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quo,
  output logic [W-1:0] rem
);

  localparam int CW = $clog2(W + 1);

  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;
  logic [W:0]    shifted;
  logic [W:0]    diff;

  assign shifted = {rem_r, quo_r[W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign done    = busy_r && (cnt_r == '0);
  assign quo     = quo_r;
  assign rem     = rem_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - CW'(1);
        if (!diff[W]) begin
          rem_nxt = diff[W-1:0];
          quo_nxt = {quo_r[W-2:0], 1'b1};
        end else begin
          rem_nxt = shifted[W-1:0];
          quo_nxt = {quo_r[W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

endmodule

/* hdl/mixed_fraction_normalizer.sv */
// Mixed fraction normaliser: whole-part extraction and Euclidean reduction.
// The sequencer makes one divider run for extraction when num >= den, one per Euclid step,
// and two more when the divisor found exceeds one. A zero denominator or a zero input numerator
// skips the divider. One transaction at a time: a new input is accepted only in idle, after the
// last result has been registered at the output. Synchronous active-low reset returns the
// sequencer to idle and empties the output.
module mixed_fraction_normalizer
  import mfn_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int W = VALUE_BITS;
  localparam logic [W-1:0] MAX_VAL = {W{1'b1}};

  state_t       state_r, state_nxt;
  logic [W-1:0] whole_r, whole_nxt;
  logic [W-1:0] num_r, num_nxt;
  logic [W-1:0] den_r, den_nxt;
  logic [W-1:0] b_r, b_nxt;
  logic [1:0]   status_r, status_nxt;
  out_t         out_r, out_nxt;
  logic         out_valid_r, out_valid_nxt;

  logic         div_start;
  logic [W-1:0] div_dvd;
  logic [W-1:0] div_dvs;
  logic         div_done;
  logic [W-1:0] div_quo;
  logic [W-1:0] div_rem;

  logic [W-1:0] n_in, d_in, w_in;

  assign n_in = W'(in_data.num_in);
  assign d_in = W'(in_data.den_in);
  assign w_in = W'(in_data.whole_in);

  mfn_divider #(.W(W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    whole_nxt     = whole_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    b_nxt         = b_r;
    status_nxt    = status_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    div_start     = 1'b0;
    div_dvd       = num_r;
    div_dvs       = b_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          whole_nxt  = w_in;
          num_nxt    = n_in;
          den_nxt    = d_in;
          status_nxt = ST_OK;
          if (d_in == '0) begin
            status_nxt = ST_ZERO_DEN;
            state_nxt  = S_DONE;
          end else if (n_in >= d_in) begin
            div_start = 1'b1;
            div_dvd   = n_in;
            div_dvs   = d_in;
            state_nxt = S_EXTRACT;
          end else if (n_in == '0) begin
            state_nxt = S_DONE;
          end else begin
            div_start = 1'b1;
            div_dvd   = d_in;
            div_dvs   = n_in;
            b_nxt     = n_in;
            state_nxt = S_GCD;
          end
        end
      end
      S_EXTRACT: begin
        if (div_done) begin
          num_nxt = div_rem;
          if (div_quo > ~whole_r) begin
            whole_nxt  = MAX_VAL;
            status_nxt = ST_SATURATED;
          end else begin
            whole_nxt = whole_r + div_quo;
          end
          if (div_rem == '0) begin
            state_nxt = S_DONE;
          end else begin
            div_start = 1'b1;
            div_dvd   = den_r;
            div_dvs   = div_rem;
            b_nxt     = div_rem;
            state_nxt = S_GCD;
          end
        end
      end
      S_GCD: begin
        if (div_done) begin
          if (div_rem == '0) begin
            if (b_r > W'(1)) begin
              div_start = 1'b1;
              div_dvd   = num_r;
              div_dvs   = b_r;
              state_nxt = S_DIVN;
            end else begin
              state_nxt = S_DONE;
            end
          end else begin
            div_start = 1'b1;
            div_dvd   = b_r;
            div_dvs   = div_rem;
            b_nxt     = div_rem;
          end
        end
      end
      S_DIVN: begin
        if (div_done) begin
          num_nxt   = div_quo;
          div_start = 1'b1;
          div_dvd   = den_r;
          div_dvs   = b_r;
          state_nxt = S_DIVD;
        end
      end
      S_DIVD: begin
        if (div_done) begin
          den_nxt   = div_quo;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.whole_out = 32'(whole_r);
          out_nxt.num_out   = 32'(num_r);
          out_nxt.den_out   = 32'(den_r);
          out_nxt.status    = status_r;
          out_valid_nxt     = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    whole_r  <= whole_nxt;
    num_r    <= num_nxt;
    den_r    <= den_nxt;
    b_r      <= b_nxt;
    status_r <= status_nxt;
    out_r    <= out_nxt;
  end

endmodule
